// ===== sv/ufifo_pkg.sv =====
// ----------------------------------------------------------------------------
// ufifo_pkg
// Shared types and codes for the UART FIFO block with receive-idle interrupt.
// ----------------------------------------------------------------------------
package ufifo_pkg;

   // Request command codes
   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_READ  = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_RX    = 3'd3,
      CMD_DRAIN = 3'd4,
      CMD_RESET = 3'd5
   } cmd_type;

   // Bus register indexes
   localparam logic [3:0] REG_CTRL = 4'd0;
   localparam logic [3:0] REG_RX   = 4'd1;
   localparam logic [3:0] REG_TX   = 4'd2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_RELOAD   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IRQ_THRESHOLD = 1'd1;

   // Reset values of the configuration registers
   localparam logic [7:0] IDLE_RELOAD_RST   = 8'd100;
   localparam logic [3:0] IRQ_THRESHOLD_RST = 4'd3;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HOLD
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the request word and read both stores
      logic execute;   // update state and load the response register
   } ctl_cmd_type;

endpackage

// ===== sv/ufifo_ctrl.sv =====
// ----------------------------------------------------------------------------
// ufifo_ctrl
// Sequencer: accept a request word, execute it, hold the response word.
// ----------------------------------------------------------------------------
module ufifo_ctrl
   import ufifo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ctl_cmd_type ctl_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_stall       = 1'b1;
      rsp_valid       = 1'b0;
      ctl_cmd.capture = 1'b0;
      ctl_cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl_cmd.capture = 1'b1;
               state_in        = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl_cmd.execute = 1'b1;
            state_in        = ST_HOLD;
         end
         ST_HOLD: begin
            rsp_valid = 1'b1;
            // take the next word in the cycle the response leaves
            req_stall = rsp_stall;
            if (!rsp_stall) begin
               if (req_valid) begin
                  ctl_cmd.capture = 1'b1;
                  state_in        = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.capture |=> ctl_cmd.execute)
      else $error("captured word not executed next cycle");

   a_exec_then_rsp: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.execute |=> rsp_valid)
      else $error("executed word gave no response");

   a_stalled_rsp_no_exec: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> !ctl_cmd.execute)
      else $error("response register overwritten while stalled");

endmodule

// ===== sv/ufifo_dp.sv =====
// ----------------------------------------------------------------------------
// ufifo_dp
// Datapath: receive and transmit stores, pointers, idle counter, config.
// ----------------------------------------------------------------------------
module ufifo_dp
   import ufifo_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
)(
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          ctl_cmd,
   input  logic [2:0]           req_cmd,
   input  logic [3:0]           req_reg_index,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_reset_level,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   output logic [7:0]           rsp_read_data,
   output logic                 rsp_irq_drive,
   output logic                 rsp_irq_level
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = (PTR_W > 4) ? PTR_W : 4;
   localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W+1)'(FIFO_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] fill_of(input logic [PTR_W-1:0] tail,
                                                 input logic [PTR_W-1:0] head);
      logic [PTR_W:0] sum;
      sum = {1'b0, tail} + ((tail < head) ? DEPTH_X : '0) - {1'b0, head};
      return CNT_W'(sum[PTR_W-1:0]);
   endfunction

   // Request word
   logic [2:0] cmd_ff;
   logic [3:0] reg_ff;
   logic [7:0] data_ff;
   logic       level_ff;

   // Stores with per-entry valid bits; an invalid entry reads as zero
   logic [7:0]            rx_mem_ff [FIFO_DEPTH];
   logic [7:0]            tx_mem_ff [FIFO_DEPTH];
   logic [FIFO_DEPTH-1:0] rx_vld_ff, rx_vld_in;
   logic [FIFO_DEPTH-1:0] tx_vld_ff, tx_vld_in;
   logic [7:0]            rx_rd_ff;
   logic [7:0]            tx_rd_ff;

   logic [PTR_W-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [PTR_W-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [7:0]       idle_ff, idle_in;
   logic             held_ff, held_in;
   logic [7:0]       reload_ff;
   logic [3:0]       thresh_ff;

   logic [7:0] rd_in;
   logic       drive_in, irq_in;
   logic       rx_wr, tx_wr, rx_upd;
   logic [7:0] idle_dec;
   logic [7:0] rx_byte, tx_byte;
   logic [CNT_W-1:0] rx_cnt, tx_cnt, rx_cnt_new;

   assign rx_cnt  = fill_of(rx_tail_ff, rx_head_ff);
   assign tx_cnt  = fill_of(tx_tail_ff, tx_head_ff);
   assign rx_byte = rx_vld_ff[rx_head_ff] ? rx_rd_ff : 8'd0;
   assign tx_byte = tx_vld_ff[tx_head_ff] ? tx_rd_ff : 8'd0;
   assign idle_dec = idle_ff - 8'd1;

   always_comb begin
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      rx_vld_in  = rx_vld_ff;
      tx_vld_in  = tx_vld_ff;
      idle_in    = idle_ff;
      held_in    = held_ff;
      rd_in      = 8'd0;
      drive_in   = 1'b0;
      irq_in     = 1'b0;
      rx_wr      = 1'b0;
      tx_wr      = 1'b0;
      rx_upd     = 1'b0;
      rx_cnt_new = '0;
      case (cmd_ff)
         CMD_TICK: begin
            if (idle_dec == 8'd0 && rx_cnt != '0) begin
               drive_in = 1'b1;
               irq_in   = 1'b1;
               idle_in  = reload_ff;
            end else begin
               idle_in = idle_dec;
            end
         end
         CMD_READ: begin
            if (reg_ff == REG_CTRL) begin
               rd_in = {tx_cnt[3:0], rx_cnt[3:0]};
            end else if (reg_ff == REG_RX && !held_ff) begin
               rd_in      = rx_byte;
               rx_head_in = ptr_next(rx_head_ff);
               rx_upd     = 1'b1;
            end
         end
         CMD_WRITE: begin
            if (reg_ff == REG_TX && !held_ff) begin
               tx_wr                 = 1'b1;
               tx_vld_in[tx_tail_ff] = 1'b1;
               tx_tail_in            = ptr_next(tx_tail_ff);
            end
         end
         CMD_RX: begin
            if (!held_ff) begin
               rx_wr                 = 1'b1;
               rx_vld_in[rx_tail_ff] = 1'b1;
               rx_tail_in            = ptr_next(rx_tail_ff);
               idle_in               = reload_ff;
               rx_upd                = 1'b1;
            end
         end
         CMD_DRAIN: begin
            if (!held_ff) begin
               rd_in      = tx_byte;
               tx_head_in = ptr_next(tx_head_ff);
            end
         end
         CMD_RESET: begin
            held_in = level_ff;
            if (level_ff) begin
               rx_head_in = '0;
               rx_tail_in = '0;
               tx_head_in = '0;
               tx_tail_in = '0;
               rx_vld_in  = '0;
               tx_vld_in  = '0;
            end
         end
         default: begin
         end
      endcase
      // drive the interrupt from the level after the receive update
      if (rx_upd) begin
         rx_cnt_new = fill_of(rx_tail_in, rx_head_in);
         drive_in   = 1'b1;
         irq_in     = (rx_cnt_new > CNT_W'(thresh_ff));
      end
   end

   // Request word and store reads at capture
   always_ff @(posedge clock) begin
      if (ctl_cmd.capture) begin
         cmd_ff   <= req_cmd;
         reg_ff   <= req_reg_index;
         data_ff  <= req_data_byte;
         level_ff <= req_reset_level;
         rx_rd_ff <= rx_mem_ff[rx_head_ff];
         tx_rd_ff <= tx_mem_ff[tx_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.execute && rx_wr) begin
         rx_mem_ff[rx_tail_ff] <= data_ff;
      end
      if (ctl_cmd.execute && tx_wr) begin
         tx_mem_ff[tx_tail_ff] <= data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
         rx_vld_ff  <= '0;
         tx_vld_ff  <= '0;
         idle_ff    <= IDLE_RELOAD_RST;
         held_ff    <= 1'b0;
      end else if (ctl_cmd.execute) begin
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
         rx_vld_ff  <= rx_vld_in;
         tx_vld_ff  <= tx_vld_in;
         idle_ff    <= idle_in;
         held_ff    <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= IDLE_RELOAD_RST;
         thresh_ff <= IRQ_THRESHOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IDLE_RELOAD:   reload_ff <= csr_wdata;
            CSR_IRQ_THRESHOLD: thresh_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (ctl_cmd.execute) begin
         rsp_read_data <= rd_in;
         rsp_irq_drive <= drive_in;
         rsp_irq_level <= irq_in;
      end
   end

endmodule

// ===== sv/uart_fifo_with_idle_irq_core.sv =====
// ----------------------------------------------------------------------------
// uart_fifo_with_idle_irq_core
// UART receive/transmit byte FIFOs with a threshold and receive-idle interrupt.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request word (tick, bus read, bus write, received byte,
//   transmit drain, reset level). A word is taken when req_valid is high and
//   req_stall is low. Every request gives exactly one response word on rsp_*
//   (read data, interrupt drive and level), taken when rsp_valid is high and
//   rsp_stall is low.
//   csr_* writes the idle reload (index 0) and irq threshold (index 1);
//   csr_ready is always high. Write them only while no word is in flight.
//   The request is latched and both stores are read at the edge that takes
//   it; it executes in the EXEC state, which loads the response register,
//   and the response is offered from the HOLD state. A new request is taken
//   only while idle or in the same cycle the previous response leaves, so
//   the block takes no new word until the last response has left.
//   While the receiver holds rsp_stall, the response is held and req_stall
//   stays high. Reset clears pointers, valid bits, counters and the config
//   registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module uart_fifo_with_idle_irq_core
   import ufifo_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_cmd,
   input  logic [3:0]           req_reg_index,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_reset_level,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_read_data,
   output logic                 rsp_irq_drive,
   output logic                 rsp_irq_level,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   ctl_cmd_type ctl_cmd;

   // Config writes land directly in their registers, so never back-pressure them
   assign csr_ready = 1'b1;

   ufifo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl_cmd   (ctl_cmd)
   );

   ufifo_dp #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl_cmd         (ctl_cmd),
      .req_cmd         (req_cmd),
      .req_reg_index   (req_reg_index),
      .req_data_byte   (req_data_byte),
      .req_reset_level (req_reset_level),
      .csr_we          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_drive   (rsp_irq_drive),
      .rsp_irq_level   (rsp_irq_level)
   );

endmodule
